/* sv/hmst_pkg.sv */
// Types and constants shared by the countdown timer modules.
package hmst_pkg;

    typedef enum logic [1:0] {
        MODE_RUNNING = 2'd0,
        MODE_STANDBY = 2'd1,
        MODE_SETTING = 2'd2,
        MODE_PAUSE   = 2'd3
    } t_mode;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_SELECT = 3'd1;
    localparam logic [2:0] OP_UP     = 3'd2;
    localparam logic [2:0] OP_DOWN   = 3'd3;
    localparam logic [2:0] OP_SLOT   = 3'd4;
    localparam logic [2:0] OP_LOAD   = 3'd5;

    localparam logic [1:0] FIELD_HOURS   = 2'd0;
    localparam logic [1:0] FIELD_MINUTES = 2'd1;
    localparam logic [1:0] FIELD_SECONDS = 2'd2;

    localparam logic [0:0] CFG_TICKS_PER_SECOND = 1'd0;
    localparam logic [0:0] CFG_LONG_PRESS_TICKS = 1'd1;

    localparam logic [4:0] HOURS_MAX     = 5'd23;
    localparam logic [5:0] MINSEC_MAX    = 6'd59;
    localparam logic [2:0] SLOT_FIRST    = 3'd1;
    localparam logic [2:0] SLOT_LAST     = 3'd5;
    localparam logic [7:0] TPS_RESET     = 8'd100;
    localparam logic [7:0] LONG_RESET    = 8'd80;
    localparam logic [7:0] LED_RESET     = 8'd25;
    localparam logic [5:0] MINUTES_RESET = 6'd1;
    localparam logic [5:0] SECONDS_RESET = 6'd55;

    typedef struct packed {
        logic [2:0] opcode;
        logic       select_held;
        logic       up_held;
        logic       down_held;
        logic [4:0] load_hours;
        logic [5:0] load_minutes;
        logic [5:0] load_seconds;
    } t_in_word;

    typedef struct packed {
        logic [4:0] hours_now;
        logic [5:0] minutes_now;
        logic [5:0] seconds_now;
        logic [1:0] run_state;
        logic [1:0] field_selected;
        logic [2:0] slot_now;
        logic       buzzer_pwm_on;
        logic       led_on;
        logic       save_request;
        logic       load_request;
    } t_out_word;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [7:0] subsec;
        t_mode      mode;
        logic [1:0] field;
        logic [2:0] slot;
        logic       press_pending;
        logic [7:0] press_count;
        logic [7:0] led_count;
        logic       led_level;
    } t_state;

    typedef struct packed {
        logic [7:0] ticks_per_second;
        logic [7:0] long_press_ticks;
    } t_cfg;

endpackage

/* sv/hmst_in_if.sv */
// Valid/ready channel carrying one input word.
interface hmst_in_if;
    logic                valid;
    logic                ready;
    hmst_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/hmst_out_if.sv */
// Valid/ready channel carrying one result word.
interface hmst_out_if;
    logic                valid;
    logic                ready;
    hmst_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/hms_countdown_timer_with_keys.sv */
// Top level of the hours:minutes:seconds countdown timer with key events.
//
//   channel   dir   handshake          word
//   i_in      in    valid/ready        t_in_word  (event and key levels)
//   o_out     out   valid/ready        t_out_word (time, mode, requests)
//   i_cfg_*   in    write enable only  1-bit index, 8-bit data
//
// One event per cycle while i_in.ready is high; each result is registered.
// The timer state updates at the accepting edge; the result sits in an output
// register backed by one skid entry, so ready drops only when both are full.
// Reset restores the power-on time 0:01:55, running mode and default registers.
module hms_countdown_timer_with_keys (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hmst_in_if.sink    i_in,
    hmst_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import hmst_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_cfg      r_cfg;
    t_out_word step_word;
    t_out_word r_out_word;
    t_out_word n_out_word;
    t_out_word r_skid_word;
    logic      r_out_valid;
    logic      n_out_valid;
    logic      r_skid_valid;
    logic      n_skid_valid;
    logic      in_take;
    logic      out_take;

    hmst_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_word  (i_in.data),
        .o_state (n_state),
        .o_word  (step_word)
    );

    assign i_in.ready  = !r_skid_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;
    assign in_take     = i_in.valid && i_in.ready;
    assign out_take    = r_out_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_second <= TPS_RESET;
            r_cfg.long_press_ticks <= LONG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TICKS_PER_SECOND: r_cfg.ticks_per_second <= i_cfg_data;
                CFG_LONG_PRESS_TICKS: r_cfg.long_press_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.hours         <= 5'd0;
            r_state.minutes       <= MINUTES_RESET;
            r_state.seconds       <= SECONDS_RESET;
            r_state.subsec        <= TPS_RESET;
            r_state.mode          <= MODE_RUNNING;
            r_state.field         <= FIELD_HOURS;
            r_state.slot          <= SLOT_FIRST;
            r_state.press_pending <= 1'b0;
            r_state.press_count   <= 8'd0;
            r_state.led_count     <= LED_RESET;
            r_state.led_level     <= 1'b0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_word   = r_out_word;
        if (out_take) begin
            if (r_skid_valid) begin
                n_out_word   = r_skid_word;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = in_take;
                n_out_word  = step_word;
            end
        end else if (in_take) begin
            if (!r_out_valid) begin
                n_out_valid = 1'b1;
                n_out_word  = step_word;
            end else begin
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        if (in_take && r_out_valid && !out_take) begin
            r_skid_word <= step_word;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output word");

    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && !r_out_valid) |=> r_out_valid)
        else $error("accepted event produced no result word");

    a_buzzer_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_word.buzzer_pwm_on == (r_out_word.run_state == MODE_RUNNING)))
        else $error("buzzer enable disagrees with run state");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_word.save_request && r_out_word.load_request))
        else $error("save and load requested in one word");
endmodule

/* sv/hmst_step.sv */
// Next-state and result logic for one timer event.
module hmst_step (
    input  hmst_pkg::t_state    i_state,
    input  hmst_pkg::t_cfg      i_cfg,
    input  hmst_pkg::t_in_word  i_word,
    output hmst_pkg::t_state    o_state,
    output hmst_pkg::t_out_word o_word
);
    import hmst_pkg::*;

    t_state     n;
    logic       save;
    logic       load;
    logic [7:0] sub_dec;

    assign sub_dec = i_state.subsec - 8'd1;

    always_comb begin
        n    = i_state;
        save = 1'b0;
        load = 1'b0;
        case (i_word.opcode)
            OP_TICK: begin
                if (i_state.mode == MODE_RUNNING) begin
                    n.subsec = sub_dec;
                    if (sub_dec == 8'd0) begin
                        n.subsec = i_cfg.ticks_per_second;
                        if (i_state.hours == 5'd0 && i_state.minutes == 6'd0
                            && i_state.seconds == 6'd0) begin
                            n.mode = MODE_STANDBY;
                        end else begin
                            if (i_state.seconds != 6'd0) begin
                                n.seconds = i_state.seconds - 6'd1;
                            end else if (i_state.minutes != 6'd0) begin
                                n.minutes = i_state.minutes - 6'd1;
                                n.seconds = MINSEC_MAX;
                            end else begin
                                n.hours   = i_state.hours - 5'd1;
                                n.minutes = MINSEC_MAX;
                                n.seconds = MINSEC_MAX;
                            end
                            if (n.hours == 5'd0 && n.minutes == 6'd0 && n.seconds == 6'd0) begin
                                n.mode = MODE_STANDBY;
                            end
                        end
                    end
                end
                if (i_state.press_pending) begin
                    if (i_state.press_count != 8'd0) begin
                        n.press_count = i_state.press_count - 8'd1;
                    end else begin
                        if (i_word.select_held) begin
                            save = 1'b1;
                        end else if (!i_word.up_held && i_word.down_held) begin
                            n.mode = MODE_STANDBY;
                        end
                        n.press_pending = 1'b0;
                        n.press_count   = 8'd0;
                    end
                end
                n.led_count = i_state.led_count - 8'd1;
                if (n.led_count == 8'd0 && n.mode == MODE_RUNNING) begin
                    n.led_level = !i_state.led_level;
                end
            end
            OP_SELECT: begin
                n.press_pending = 1'b1;
                n.press_count   = i_cfg.long_press_ticks;
                n.mode          = MODE_SETTING;
                n.field         = (i_state.field >= FIELD_SECONDS) ? FIELD_HOURS
                                                                    : i_state.field + 2'd1;
            end
            OP_UP: begin
                n.press_pending = 1'b1;
                n.press_count   = i_cfg.long_press_ticks;
                if (i_state.mode == MODE_SETTING) begin
                    case (i_state.field)
                        FIELD_HOURS: begin
                            n.hours = (i_state.hours >= HOURS_MAX) ? 5'd0
                                                                   : i_state.hours + 5'd1;
                        end
                        FIELD_MINUTES: begin
                            n.minutes = (i_state.minutes >= MINSEC_MAX) ? 6'd0
                                                                        : i_state.minutes + 6'd1;
                        end
                        default: begin
                            n.seconds = (i_state.seconds >= MINSEC_MAX) ? 6'd0
                                                                        : i_state.seconds + 6'd1;
                        end
                    endcase
                end
            end
            OP_DOWN: begin
                n.press_pending = 1'b1;
                n.press_count   = i_cfg.long_press_ticks;
                if (i_state.mode == MODE_SETTING) begin
                    case (i_state.field)
                        FIELD_HOURS: begin
                            n.hours = (i_state.hours == 5'd0) ? HOURS_MAX
                                                              : i_state.hours - 5'd1;
                        end
                        FIELD_MINUTES: begin
                            n.minutes = (i_state.minutes == 6'd0) ? MINSEC_MAX
                                                                  : i_state.minutes - 6'd1;
                        end
                        default: begin
                            n.seconds = (i_state.seconds == 6'd0) ? MINSEC_MAX
                                                                  : i_state.seconds - 6'd1;
                        end
                    endcase
                end
                n.mode = (i_state.mode == MODE_RUNNING) ? MODE_PAUSE : MODE_RUNNING;
            end
            OP_SLOT: begin
                n.slot = (i_state.slot >= SLOT_LAST) ? SLOT_FIRST : i_state.slot + 3'd1;
                load   = 1'b1;
            end
            OP_LOAD: begin
                n.hours   = (i_word.load_hours > HOURS_MAX) ? HOURS_MAX : i_word.load_hours;
                n.minutes = (i_word.load_minutes > MINSEC_MAX) ? MINSEC_MAX
                                                                : i_word.load_minutes;
                n.seconds = (i_word.load_seconds > MINSEC_MAX) ? MINSEC_MAX
                                                                : i_word.load_seconds;
            end
            default: begin
            end
        endcase
    end

    assign o_state = n;

    always_comb begin
        o_word.hours_now      = n.hours;
        o_word.minutes_now    = n.minutes;
        o_word.seconds_now    = n.seconds;
        o_word.run_state      = n.mode;
        o_word.field_selected = n.field;
        o_word.slot_now       = n.slot;
        o_word.buzzer_pwm_on  = (n.mode == MODE_RUNNING);
        o_word.led_on         = n.led_level;
        o_word.save_request   = save;
        o_word.load_request   = load;
    end
endmodule
